[rtl/rcg_pkg.sv]
// Shared widths, operation codes, node-count reset value and controller/datapath interface structs.
package rcg_pkg;

  localparam int OP_W   = 2;
  localparam int NODE_W = 5;
  localparam int GRP_W  = 5;
  localparam int CFG_W  = 6;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_ADD   = 2'd1;
  localparam op_t OP_RUN   = 2'd2;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 6'd32;

  typedef struct packed {
    logic clr_mat;
    logic add_edge;
    logic run_init;
    logic ld_rowk;
    logic cl_step;
    logic gr_sel;
    logic gr_scan;
    logic emit_start;
    logic gr_emit;
    logic gr_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic k_last;
    logic i_last;
    logic i_end;
    logic j_end;
    logic cur_grouped;
  } dp_stat_t;

endpackage

[rtl/rcg_ctrl.sv]
// Sequencer for clear, edge load, closure and group emission.
module rcg_ctrl
  import rcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  op_t      op,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CL_LOAD,
    S_CL_ROW,
    S_GR_SEL,
    S_GR_SCAN,
    S_GR_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_CLEAR: cmd.clr_mat  = 1'b1;
            OP_ADD:   cmd.add_edge = 1'b1;
            OP_RUN: begin
              cmd.run_init = 1'b1;
              if (!stat.n_zero) state_nxt = S_CL_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_CL_LOAD: begin
        cmd.ld_rowk = 1'b1;
        state_nxt   = S_CL_ROW;
      end
      S_CL_ROW: begin
        cmd.cl_step = 1'b1;
        if (stat.i_last) state_nxt = stat.k_last ? S_GR_SEL : S_CL_LOAD;
      end
      S_GR_SEL: begin
        if (stat.i_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.gr_sel = 1'b1;
          if (!stat.cur_grouped) state_nxt = S_GR_SCAN;
        end
      end
      S_GR_SCAN: begin
        if (stat.j_end) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_GR_EMIT;
        end else begin
          cmd.gr_scan = 1'b1;
        end
      end
      S_GR_EMIT: begin
        if (stat.j_end) begin
          cmd.gr_finish = 1'b1;
          state_nxt     = S_GR_SEL;
        end else begin
          cmd.gr_emit = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[rtl/rcg_dp.sv]
// Adjacency matrix, loop counters, group bookkeeping and result register.
module rcg_dp
  import rcg_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int IDXW = 5,
  parameter int CW   = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [CW-1:0]     n,
  input  logic [NODE_W-1:0] src,
  input  logic [NODE_W-1:0] dst,
  output dp_stat_t          stat,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_node,
  output logic [GRP_W-1:0]  out_group,
  output logic              out_lig,
  output logic              out_lor
);

  logic [ROWS-1:0] mat_r [ROWS];
  logic [CW-1:0]   k_r, i_r, j_r;
  logic [ROWS-1:0] rowk_r, rowi_r, members_r, grouped_r;
  logic [GRP_W-1:0] gcnt_r;

  logic              valid_r, lig_r, lor_r;
  logic [NODE_W-1:0] node_r;
  logic [GRP_W-1:0]  group_r;

  logic [ROWS-1:0] keep, above_j, onehot_i, rd_row;
  logic [CW-1:0]   rd_addr;
  logic            edge_ok, lig_nxt, lor_nxt;

  always_comb begin
    for (int b = 0; b < ROWS; b++) begin
      keep[b]     = (CW'(b) < n);
      above_j[b]  = (CW'(b) > j_r);
      onehot_i[b] = (CW'(b) == i_r);
    end
  end

  // one row read per cycle
  always_comb begin
    if (cmd.cl_step || cmd.gr_sel) rd_addr = i_r;
    else if (cmd.gr_scan)          rd_addr = j_r;
    else                           rd_addr = k_r;
  end
  assign rd_row = mat_r[rd_addr[IDXW-1:0]];

  assign edge_ok = ({1'b0, src} < CFG_W'(n)) && ({1'b0, dst} < CFG_W'(n));

  assign stat.n_zero      = (n == '0);
  assign stat.k_last      = (CW'(k_r + 1'b1) == n);
  assign stat.i_last      = (CW'(i_r + 1'b1) == n);
  assign stat.i_end       = (i_r >= n);
  assign stat.j_end       = (j_r >= n);
  assign stat.cur_grouped = (i_r < n) && grouped_r[i_r[IDXW-1:0]];

  assign lig_nxt = ((members_r & above_j) == '0);
  assign lor_nxt = lig_nxt && (((grouped_r | members_r) & keep) == keep);

  // matrix
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_mat) begin
      for (int r = 0; r < ROWS; r++) mat_r[r] <= '0;
    end else if (cmd.add_edge) begin
      if (edge_ok) mat_r[src[IDXW-1:0]][dst[IDXW-1:0]] <= 1'b1;
    end else if (cmd.cl_step && rd_row[k_r[IDXW-1:0]]) begin
      mat_r[i_r[IDXW-1:0]] <= rd_row | rowk_r;
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      grouped_r <= '0;
      gcnt_r    <= '0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= cmd.gr_emit && members_r[j_r[IDXW-1:0]];
      if (cmd.clr_mat) begin
        grouped_r <= '0;
        gcnt_r    <= '0;
      end
      if (cmd.run_init) begin
        k_r       <= '0;
        i_r       <= '0;
        grouped_r <= '0;
        gcnt_r    <= '0;
      end
      if (cmd.ld_rowk) i_r <= '0;
      if (cmd.cl_step) begin
        if (stat.i_last) begin
          i_r <= '0;
          k_r <= CW'(k_r + 1'b1);
        end else begin
          i_r <= CW'(i_r + 1'b1);
        end
      end
      if (cmd.gr_sel) begin
        if (stat.cur_grouped) i_r <= CW'(i_r + 1'b1);
        else                  j_r <= CW'(i_r + 1'b1);
      end
      if (cmd.gr_scan)    j_r <= CW'(j_r + 1'b1);
      if (cmd.emit_start) j_r <= i_r;
      if (cmd.gr_emit) begin
        j_r <= CW'(j_r + 1'b1);
      end
      if (cmd.gr_finish) begin
        grouped_r <= grouped_r | members_r;
        gcnt_r    <= GRP_W'(gcnt_r + 1'b1);
        i_r       <= CW'(i_r + 1'b1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.ld_rowk) rowk_r <= rd_row & keep;
    if (cmd.gr_sel) begin
      rowi_r    <= rd_row;
      members_r <= onehot_i;
    end
    if (cmd.gr_scan) begin
      members_r[j_r[IDXW-1:0]] <= members_r[j_r[IDXW-1:0]]
                                  | (rd_row[i_r[IDXW-1:0]] && rowi_r[j_r[IDXW-1:0]]
                                     && !grouped_r[j_r[IDXW-1:0]]);
    end
    if (cmd.gr_emit) begin
      node_r  <= NODE_W'(j_r);
      group_r <= gcnt_r;
      lig_r   <= lig_nxt;
      lor_r   <= lor_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_node  = node_r;
  assign out_group = group_r;
  assign out_lig   = lig_r;
  assign out_lor   = lor_r;

endmodule

[rtl/reachability_class_grouper.sv]
// Top level: directed-graph closure and mutual-reachability grouping.
//
// Usage:
//   A transaction is taken when start is high and busy is low. in_operation
//   selects: clear the adjacency matrix, add edge in_src_node -> in_dst_node,
//   or run. Clear and add leave busy low, so they can be
//   issued back to back. Edges naming a node at or above the active node
//   count are dropped.
//   A run forms the transitive closure in place (one row update per cycle
//   in the row phase, after a load of row k for each k, set by the single
//   matrix row port), then groups nodes that reach each other both ways.
//   Grouping visits each node position in order; for a node not yet
//   grouped it scans the later nodes for mutual reachability, then emits
//   every member of the group; a closing step ends the run. Results come out
//   on the out_ ports for one cycle each, marked by out_valid; the receiver
//   cannot stall them. out_last_in_group and out_last_of_run flag group and
//   run ends. busy stays high until the run is done; an n of zero makes the
//   run a no-op. cfg_wr_en writes the node count (reset 32); the user must
//   write it only while idle; the block does not enforce this.
//   Reset (synchronous, active low) clears the matrix and all control state.
module reachability_class_grouper
  import rcg_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [NODE_W-1:0] in_src_node,
  input  logic [NODE_W-1:0] in_dst_node,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_node_index,
  output logic [GRP_W-1:0]  out_group_index,
  output logic              out_last_in_group,
  output logic              out_last_of_run,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data
);

  // matrix holds at most 32 rows; node fields are 5 bits wide
  localparam int ROWS = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int IDXW = $clog2(ROWS);
  localparam int CW   = $clog2(ROWS + 1);

  logic [CFG_W-1:0] node_count_r;
  logic [CW-1:0]    n_act;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // active node count, saturated to the matrix size
  assign n_act = (node_count_r > CFG_W'(ROWS)) ? CW'(ROWS) : CW'(node_count_r);

  rcg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (op_t'(in_operation)),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rcg_dp #(
    .ROWS (ROWS),
    .IDXW (IDXW),
    .CW   (CW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .n         (n_act),
    .src       (in_src_node),
    .dst       (in_dst_node),
    .stat      (stat),
    .out_valid (out_valid),
    .out_node  (out_node_index),
    .out_group (out_group_index),
    .out_lig   (out_last_in_group),
    .out_lor   (out_last_of_run)
  );

  // results only appear while a run is in progress
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a run");

  // clear and add never occupy the block
  a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_RUN) |=> !busy)
    else $error("clear or add left block busy");

  // nothing follows the last result of a run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !out_valid)
    else $error("result after end of run");

  // end of run is always also end of a group
  a_run_end_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> out_last_in_group)
    else $error("run ended inside a group");

endmodule
